// ===== hw/rtl/ptri_pkg.sv =====
// Types, widths, status codes and saturation helper for the planar trilateration solver.
package ptri_pkg;

  localparam int CW    = 16;
  localparam int DW    = CW + 2;
  localparam int LW    = (2 * CW + 4 > 64) ? 64 : 2 * CW + 4;
  localparam int DETW  = (2 * CW + 4 > 64) ? 64 : 2 * CW + 4;
  localparam int NUMW  = (3 * CW + 6 > 64) ? 64 : 3 * CW + 6;
  localparam int N2W_R = (2 * CW + 5 > CW + 34) ? 2 * CW + 5 : CW + 34;
  localparam int N2W   = (N2W_R > 64) ? 64 : N2W_R;
  localparam int OUTW  = 32;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DET_ZERO = 2'd1;
  localparam logic [1:0] ST_Y_ZERO   = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] anchor_a_x;
    logic signed [CW-1:0] anchor_a_y;
    logic signed [CW-1:0] anchor_a_z;
    logic signed [CW-1:0] anchor_b_x;
    logic signed [CW-1:0] anchor_b_y;
    logic signed [CW-1:0] anchor_b_z;
    logic signed [CW-1:0] anchor_c_x;
    logic signed [CW-1:0] anchor_c_y;
    logic signed [CW-1:0] anchor_c_z;
    logic        [CW-1:0] range_a;
    logic        [CW-1:0] range_b;
    logic        [CW-1:0] range_c;
  } ptri_in_t;

  typedef struct packed {
    logic signed [OUTW-1:0] pos_x;
    logic signed [OUTW-1:0] pos_y;
    logic        [1:0]      status;
  } ptri_out_t;

  typedef struct packed {
    logic signed [DETW-1:0] det;
    logic signed [NUMW-1:0] num;
    logic signed [LW-1:0]   abr;
    logic signed [DW-1:0]   abx;
    logic signed [DW-1:0]   aby;
  } ptri_front_t;

  typedef struct packed {
    logic                 neg;
    logic                 det_zero;
    logic                 aby_zero;
    logic signed [LW-1:0] abr;
    logic signed [DW-1:0] abx;
    logic signed [DW-1:0] aby;
  } ptri_mid_t;

  typedef struct packed {
    logic                   neg;
    logic                   det_zero;
    logic                   aby_zero;
    logic signed [OUTW-1:0] x;
  } ptri_back_t;

  function automatic logic signed [OUTW-1:0] sat32(input logic signed [63:0] v);
    logic signed [OUTW-1:0] r;
    priority if (v > 64'sh000000007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 64'shFFFFFFFF80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[OUTW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ptri_div.sv =====
// Pipelined unsigned restoring divider, two quotient bits per stage, with side payload.
module ptri_div #(
  parameter int NW = 54,
  parameter int DW = 36,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  localparam int BPS = 2;
  localparam int NS  = (NW + BPS - 1) / BPS;

  logic          v_r   [NS];
  logic [DW-1:0] rem_r [NS];
  logic [NW-1:0] nq_r  [NS];
  logic [DW-1:0] den_r [NS];
  logic [PW-1:0] pay_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [NW-1:0] nq_i;
    logic [DW-1:0] d_i;
    logic [PW-1:0] p_i;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] nq_nxt;
    logic [DW:0]   trial;

    if (s == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign nq_i  = in_num;
      assign d_i   = in_den;
      assign p_i   = in_pay;
    end else begin : g_next
      assign v_i   = v_r[s-1];
      assign rem_i = rem_r[s-1];
      assign nq_i  = nq_r[s-1];
      assign d_i   = den_r[s-1];
      assign p_i   = pay_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_i;
      nq_nxt  = nq_i;
      trial   = '0;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < NW) begin
          trial  = {rem_nxt, nq_nxt[NW-1]};
          nq_nxt = {nq_nxt[NW-2:0], 1'b0};
          if (trial >= {1'b0, d_i}) begin
            trial     = trial - {1'b0, d_i};
            nq_nxt[0] = 1'b1;
          end
          rem_nxt = trial[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        nq_r[s]  <= nq_nxt;
        den_r[s] <= d_i;
        pay_r[s] <= p_i;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_quo   = nq_r[NS-1];
  assign out_pay   = pay_r[NS-1];

endmodule

// ===== hw/rtl/ptri_front.sv =====
// Line equations, determinant and x numerator over four register stages.
module ptri_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  ptri_pkg::ptri_in_t         in_data,
  input  logic signed [ptri_pkg::CW-1:0] height,
  output logic                       out_valid,
  output ptri_pkg::ptri_front_t      out_data
);
  import ptri_pkg::*;

  // stage 1: differences, squares, height terms
  logic                 v1_r;
  logic signed [DW-1:0] abx1_r, aby1_r, acx1_r, acy1_r;
  logic signed [LW-1:0] sqa_r, sqb_r, sqc_r, ra2_r, rb2_r, rc2_r, zb_r, zc_r;
  logic signed [DW-1:0] dzb, dzc;

  // stage 2: line right-hand sides
  logic                 v2_r;
  logic signed [DW-1:0] abx2_r, aby2_r, acx2_r, acy2_r;
  logic signed [LW-1:0] abr2_r, acr2_r;

  // stage 3: products
  logic                   v3_r;
  logic signed [DETW-1:0] p1_r, p2_r;
  logic signed [NUMW-1:0] p3_r, p4_r;
  logic signed [LW-1:0]   abr3_r;
  logic signed [DW-1:0]   abx3_r, aby3_r;

  // stage 4: determinant and numerator
  logic        v4_r;
  ptri_front_t f4_r;

  assign dzb = DW'(in_data.anchor_a_z) - DW'(in_data.anchor_b_z);
  assign dzc = DW'(in_data.anchor_a_z) - DW'(in_data.anchor_c_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx1_r <= (DW'(in_data.anchor_a_x) - DW'(in_data.anchor_b_x)) <<< 1;
      aby1_r <= (DW'(in_data.anchor_a_y) - DW'(in_data.anchor_b_y)) <<< 1;
      acx1_r <= (DW'(in_data.anchor_a_x) - DW'(in_data.anchor_c_x)) <<< 1;
      acy1_r <= (DW'(in_data.anchor_a_y) - DW'(in_data.anchor_c_y)) <<< 1;
      sqa_r  <= LW'(in_data.anchor_a_x) * LW'(in_data.anchor_a_x)
              + LW'(in_data.anchor_a_y) * LW'(in_data.anchor_a_y)
              + LW'(in_data.anchor_a_z) * LW'(in_data.anchor_a_z);
      sqb_r  <= LW'(in_data.anchor_b_x) * LW'(in_data.anchor_b_x)
              + LW'(in_data.anchor_b_y) * LW'(in_data.anchor_b_y)
              + LW'(in_data.anchor_b_z) * LW'(in_data.anchor_b_z);
      sqc_r  <= LW'(in_data.anchor_c_x) * LW'(in_data.anchor_c_x)
              + LW'(in_data.anchor_c_y) * LW'(in_data.anchor_c_y)
              + LW'(in_data.anchor_c_z) * LW'(in_data.anchor_c_z);
      ra2_r  <= LW'(in_data.range_a) * LW'(in_data.range_a);
      rb2_r  <= LW'(in_data.range_b) * LW'(in_data.range_b);
      rc2_r  <= LW'(in_data.range_c) * LW'(in_data.range_c);
      zb_r   <= LW'(dzb) * LW'(height);
      zc_r   <= LW'(dzc) * LW'(height);

      abx2_r <= abx1_r;
      aby2_r <= aby1_r;
      acx2_r <= acx1_r;
      acy2_r <= acy1_r;
      abr2_r <= rb2_r - ra2_r + sqa_r - sqb_r - (zb_r <<< 1);
      acr2_r <= rc2_r - ra2_r + sqa_r - sqc_r - (zc_r <<< 1);

      p1_r   <= DETW'(abx2_r) * DETW'(acy2_r);
      p2_r   <= DETW'(acx2_r) * DETW'(aby2_r);
      p3_r   <= NUMW'(abr2_r) * NUMW'(acy2_r);
      p4_r   <= NUMW'(aby2_r) * NUMW'(acr2_r);
      abr3_r <= abr2_r;
      abx3_r <= abx2_r;
      aby3_r <= aby2_r;

      f4_r.det <= p1_r - p2_r;
      f4_r.num <= p3_r - p4_r;
      f4_r.abr <= abr3_r;
      f4_r.abx <= abx3_r;
      f4_r.aby <= aby3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = f4_r;

endmodule

// ===== hw/rtl/planar_trilateration_top.sv =====
// Top level: front end, two pipelined dividers, saturation and output register.
// Throughput: one item per cycle; every stage advances together whenever the
// output register is empty or being taken, so a stall freezes the whole pipe.
// Depth is set by the two dividers, two quotient bits per stage.
// Synchronous active-low reset clears valid bits and sets height_r to 0.
module planar_trilateration_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ptri_pkg::ptri_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ptri_pkg::ptri_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic signed [ptri_pkg::CW-1:0] cfg_data
);
  import ptri_pkg::*;

  logic                 en;
  logic signed [CW-1:0] height_r;

  logic        fr_valid;
  ptri_front_t fr_data;

  // divider 1 input stage
  logic            m_v_r;
  logic [NUMW-1:0] m_num_r;
  logic [DETW-1:0] m_den_r;
  ptri_mid_t       m_pay_r;

  logic            d1_valid;
  logic [NUMW-1:0] d1_quo;
  logic [$bits(ptri_mid_t)-1:0] d1_pay_vec;
  ptri_mid_t       d1_pay;
  logic [63:0]     d1_q64;

  // x stages
  logic                   x1_v_r, x2_v_r, x3_v_r;
  ptri_mid_t              x1_m_r, x2_m_r;
  logic signed [OUTW-1:0] x1_x_r, x2_x_r;
  logic signed [N2W-1:0]  x2_prod_r;
  logic signed [N2W-1:0]  n2;
  logic [N2W-1:0]         x3_num_r;
  logic [DW-1:0]          x3_den_r;
  ptri_back_t             x3_pay_r;

  logic            d2_valid;
  logic [N2W-1:0]  d2_quo;
  logic [$bits(ptri_back_t)-1:0] d2_pay_vec;
  ptri_back_t      d2_pay;
  logic [63:0]     d2_q64;

  logic      o_v_r;
  ptri_out_t o_r;
  ptri_out_t o_nxt;

  assign en        = !o_v_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= '0;
    end else if (cfg_valid) begin
      height_r <= cfg_data;
    end
  end

  ptri_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .height    (height_r),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r  <= 1'b0;
      x1_v_r <= 1'b0;
      x2_v_r <= 1'b0;
      x3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      m_v_r  <= fr_valid;
      x1_v_r <= d1_valid;
      x2_v_r <= x1_v_r;
      x3_v_r <= x2_v_r;
      o_v_r  <= d2_valid;
    end
  end

  // sign and magnitude for x division
  always_ff @(posedge clk) begin
    if (en) begin
      m_num_r          <= fr_data.num[NUMW-1] ? NUMW'(-fr_data.num) : NUMW'(fr_data.num);
      m_den_r          <= fr_data.det[DETW-1] ? DETW'(-fr_data.det) : DETW'(fr_data.det);
      m_pay_r.neg      <= fr_data.num[NUMW-1] ^ fr_data.det[DETW-1];
      m_pay_r.det_zero <= (fr_data.det == '0);
      m_pay_r.aby_zero <= (fr_data.aby == '0);
      m_pay_r.abr      <= fr_data.abr;
      m_pay_r.abx      <= fr_data.abx;
      m_pay_r.aby      <= fr_data.aby;
    end
  end

  ptri_div #(
    .NW (NUMW),
    .DW (DETW),
    .PW ($bits(ptri_mid_t))
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m_v_r),
    .in_num    (m_num_r),
    .in_den    (m_den_r),
    .in_pay    (m_pay_r),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_pay   (d1_pay_vec)
  );

  assign d1_pay = d1_pay_vec;
  assign d1_q64 = d1_pay.neg ? (64'd0 - 64'(d1_quo)) : 64'(d1_quo);
  assign n2     = N2W'(x2_m_r.abr) - x2_prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_x_r <= sat32($signed(d1_q64));
      x1_m_r <= d1_pay;

      x2_x_r    <= x1_x_r;
      x2_m_r    <= x1_m_r;
      x2_prod_r <= N2W'(x1_m_r.abx) * N2W'(x1_x_r);

      x3_num_r          <= n2[N2W-1] ? N2W'(-n2) : N2W'(n2);
      x3_den_r          <= x2_m_r.aby[DW-1] ? DW'(-x2_m_r.aby) : DW'(x2_m_r.aby);
      x3_pay_r.neg      <= n2[N2W-1] ^ x2_m_r.aby[DW-1];
      x3_pay_r.det_zero <= x2_m_r.det_zero;
      x3_pay_r.aby_zero <= x2_m_r.aby_zero;
      x3_pay_r.x        <= x2_x_r;
    end
  end

  ptri_div #(
    .NW (N2W),
    .DW (DW),
    .PW ($bits(ptri_back_t))
  ) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x3_v_r),
    .in_num    (x3_num_r),
    .in_den    (x3_den_r),
    .in_pay    (x3_pay_r),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_pay   (d2_pay_vec)
  );

  assign d2_pay = d2_pay_vec;
  assign d2_q64 = d2_pay.neg ? (64'd0 - 64'(d2_quo)) : 64'(d2_quo);

  always_comb begin
    priority if (d2_pay.det_zero) begin
      o_nxt.pos_x  = '0;
      o_nxt.pos_y  = '0;
      o_nxt.status = ST_DET_ZERO;
    end else if (d2_pay.aby_zero) begin
      o_nxt.pos_x  = d2_pay.x;
      o_nxt.pos_y  = '0;
      o_nxt.status = ST_Y_ZERO;
    end else begin
      o_nxt.pos_x  = d2_pay.x;
      o_nxt.pos_y  = sat32($signed(d2_q64));
      o_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

  a_det_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DET_ZERO |-> out_data.pos_x == '0 && out_data.pos_y == '0)
    else $error("determinant error result not cleared");

  a_y_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_Y_ZERO |-> out_data.pos_y == '0)
    else $error("y coefficient error result not cleared");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_DET_ZERO ||
                  out_data.status == ST_Y_ZERO)
    else $error("undefined status code");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== test/planar_trilateration_top_test.sv =====
// Testbench for the planar trilateration solver: directed table, random fixes, predictor check.
module planar_trilateration_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptri_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  ptri_in_t in_data;
  ptri_out_t out_data;
  logic signed [CW-1:0] cfg_data;

  planar_trilateration_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  localparam int LATENCY = 61;

  ptri_out_t fix_queue[$];
  logic signed [63:0] height;
  int errors = 0;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [63:0] div_trunc(logic signed [63:0] n, logic signed [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic ptri_out_t solve_fix(ptri_in_t f);
    logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz, ra, rb, rc;
    logic signed [63:0] abx, aby, abr, acx, acy, acr, det, num, x, y;
    ptri_out_t r;
    ax = f.anchor_a_x; ay = f.anchor_a_y; az = f.anchor_a_z;
    bx = f.anchor_b_x; by = f.anchor_b_y; bz = f.anchor_b_z;
    cx = f.anchor_c_x; cy = f.anchor_c_y; cz = f.anchor_c_z;
    ra = {48'd0, f.range_a}; rb = {48'd0, f.range_b}; rc = {48'd0, f.range_c};
    abx = 2 * (ax - bx); aby = 2 * (ay - by);
    abr = rb*rb - ra*ra + ax*ax + ay*ay + az*az - bx*bx - by*by - bz*bz
          - 2 * (az - bz) * height;
    acx = 2 * (ax - cx); acy = 2 * (ay - cy);
    acr = rc*rc - ra*ra + ax*ax + ay*ay + az*az - cx*cx - cy*cy - cz*cz
          - 2 * (az - cz) * height;
    det = abx * acy - acx * aby;
    r = '0;
    if (det == 0) begin
      r.status = ST_DET_ZERO;
      return r;
    end
    num = abr * acy - aby * acr;
    x = clamp32(div_trunc(num, det));
    r.pos_x = x[31:0];
    if (aby == 0) begin
      r.status = ST_Y_ZERO;
      return r;
    end
    y = clamp32(div_trunc(abr - abx * x, aby));
    r.pos_y = y[31:0];
    r.status = ST_OK;
    return r;
  endfunction

  // directed rows; known marks a row with a typed-in result
  typedef struct {
    ptri_in_t fix;
    bit known;
    ptri_out_t res;
  } row_t;
  row_t rows[$];

  function automatic ptri_in_t mk(int ax, int ay, int az, int bx, int by, int bz,
                                  int cx, int cy, int cz, int ra, int rb, int rc);
    ptri_in_t f;
    f.anchor_a_x = CW'(ax); f.anchor_a_y = CW'(ay); f.anchor_a_z = CW'(az);
    f.anchor_b_x = CW'(bx); f.anchor_b_y = CW'(by); f.anchor_b_z = CW'(bz);
    f.anchor_c_x = CW'(cx); f.anchor_c_y = CW'(cy); f.anchor_c_z = CW'(cz);
    f.range_a = CW'(ra); f.range_b = CW'(rb); f.range_c = CW'(rc);
    return f;
  endfunction

  function automatic ptri_in_t rand_fix();
    ptri_in_t f;
    int s;
    f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    s = $urandom_range(0, 9);
    if (s < 6) begin
      // plausible geometry: small spread, ranges drawn at random from 0 to 5000
      f.anchor_a_x = CW'($urandom_range(0, 4000) - 2000);
      f.anchor_a_y = CW'($urandom_range(0, 4000) - 2000);
      f.anchor_b_x = CW'($urandom_range(0, 4000) - 2000);
      f.anchor_b_y = CW'($urandom_range(0, 4000) - 2000);
      f.anchor_c_x = CW'($urandom_range(0, 4000) - 2000);
      f.anchor_c_y = CW'($urandom_range(0, 4000) - 2000);
      f.anchor_a_z = CW'($urandom_range(0, 1000));
      f.anchor_b_z = CW'($urandom_range(0, 1000));
      f.anchor_c_z = CW'($urandom_range(0, 1000));
      f.range_a = CW'($urandom_range(0, 5000));
      f.range_b = CW'($urandom_range(0, 5000));
      f.range_c = CW'($urandom_range(0, 5000));
    end else if (s == 6) begin
      f.anchor_b_y = f.anchor_a_y;
    end else if (s == 7) begin
      f.anchor_b_x = f.anchor_a_x; f.anchor_c_x = f.anchor_a_x;
    end else if (s == 8) begin
      f.anchor_b_x = CW'(f.anchor_a_x + 1); f.anchor_b_y = f.anchor_a_y;
      f.anchor_c_x = f.anchor_a_x; f.anchor_c_y = CW'(f.anchor_a_y + 1);
    end
    return f;
  endfunction

  task automatic write_height(logic signed [CW-1:0] h);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    height = 64'(h);
  endtask

  task automatic send_fix(ptri_in_t f);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    fix_queue.push_back(solve_fix(f));
    in_valid <= 1;
    in_data <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (fix_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    int w;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (w == 0) begin
        out_ready <= 1;
        @(posedge clk);
      end else begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    ptri_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (fix_queue.size() == 0) begin
        $display("%t unexpected item, actual %h", $time, out_data);
        errors++;
      end else begin
        e = fix_queue.pop_front();
        if (out_data.pos_x !== e.pos_x) begin
          $display("%t pos_x expected %0d actual %0d", $time, e.pos_x, out_data.pos_x);
          errors++;
        end
        if (out_data.pos_y !== e.pos_y) begin
          $display("%t pos_y expected %0d actual %0d", $time, e.pos_y, out_data.pos_y);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $display("%t status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  initial begin
    ptri_out_t k;
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    height = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    k = '0; k.status = ST_DET_ZERO;
    rows.push_back('{'0, 1, k});
    rows.push_back('{mk(5, 5, 5, 5, 5, 5, 5, 5, 5, 65535, 65535, 65535), 1, k});
    rows.push_back('{mk(-32768, 100, 0, -32768, 200, 0, -32768, -300, 0, 0, 1, 2), 1, k});
    k = '0; k.pos_x = 128; k.status = ST_Y_ZERO;
    rows.push_back('{mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0), 1, k});
    k = '0; k.pos_x = 128; k.pos_y = 128; k.status = ST_OK;
    rows.push_back('{mk(0, 0, 0, 256, 1, 0, 0, 256, 0, 181, 181, 181), 0, k});
    rows.push_back('{mk(32767, 32767, 32767, -32768, -32768, -32768,
                        32767, -32768, 0, 65535, 0, 65535), 0, k});
    rows.push_back('{mk(-32768, -32768, -32768, 32767, 32767, 32767,
                        -32768, 32767, 32767, 0, 65535, 0), 0, k});
    rows.push_back('{mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 65535, 0, 0), 0, k});
    rows.push_back('{mk(0, 0, 0, 1, 1, 0, 1, 2, 0, 0, 65535, 0), 0, k});
    rows.push_back('{mk(0, 0, 0, 1, 1, 0, 1, 2, 0, 65535, 0, 65535), 0, k});
    rows.push_back('{mk(100, 200, 300, -400, 500, -600, 700, -800, 900,
                        1000, 2000, 3000), 0, k});
    rows.push_back('{mk(-1, -1, -1, 1, -2, 1, -2, 1, -1, 1, 1, 1), 0, k});

    foreach (rows[i]) begin
      ptri_out_t p;
      p = solve_fix(rows[i].fix);
      if (rows[i].known && p != rows[i].res) begin
        $display("%t table row %0d expected %h actual %h", $time, i, rows[i].res, p);
        errors++;
      end
      send_fix(rows[i].fix);
    end
    drain();

    begin
      logic signed [CW-1:0] hs[5];
      hs = '{16'sh7FFF, -16'sh8000, 16'sh1234, -16'sh00FF, 16'sh0000};
      foreach (hs[j]) begin
        write_height(hs[j]);
        if (j == 1) hold_off = 1;
        for (int n = 0; n < 310; n++) send_fix(rand_fix());
        drain();
      end
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ptri_pkg.sv
hw/rtl/ptri_div.sv
hw/rtl/ptri_front.sv
hw/rtl/planar_trilateration_top.sv
test/planar_trilateration_top_test.sv
